### design/lrs_pkg.sv
// Shared types and constants for the linear range scaler.
package lrs_pkg;

    localparam int WORD_W = 32;
    localparam int SPAN_W = WORD_W + 1;
    localparam int PROD_W = 2 * SPAN_W - 1;
    localparam int SPLIT_W = 17;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_RAW_LOW = 2'd0;
    localparam logic [INDEX_W-1:0] REG_RAW_HIGH = 2'd1;
    localparam logic [INDEX_W-1:0] REG_EU_LOW = 2'd2;
    localparam logic [INDEX_W-1:0] REG_EU_HIGH = 2'd3;

    localparam logic OP_RAW_TO_EU = 1'b0;

    typedef struct packed {
        logic signed [SPAN_W-1:0] diff;
        logic signed [SPAN_W-1:0] span_out;
        logic signed [SPAN_W-1:0] span_in;
        logic [WORD_W-1:0]        out_lo;
        logic [WORD_W-1:0]        x;
    } item_t;

    typedef struct packed {
        logic              neg;
        logic              dz;
        logic [WORD_W-1:0] out_lo;
        logic [WORD_W-1:0] x;
    } side_t;

    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] nq;
        logic [SPAN_W-1:0] rem;
        logic [SPAN_W-1:0] den;
        side_t             side;
    } div_stage_t;

endpackage

### design/linear_range_scaler.sv
// Top level of the two-point linear range scaler.
//
// A transaction is accepted at a clock edge with start high and busy low; it
// carries operation (0 raw to engineering units, 1 the inverse) and a signed
// Q16.16 sample. The four range points are written through wr_en, wr_index
// and wr_data; the user must write them only while no transaction is in
// flight; the block leaves this check to the user. Each transaction yields
// one result: done is high for exactly one cycle with sample_out,
// divide_by_zero and saturated valid in that cycle. Results pass through
// the front, multiply and rounding stages and the 65-stage bit-per-cycle
// divider. A new transaction may be accepted every cycle; busy rises only
// if the front queue fills, which the back end never lets happen. The
// receiver cannot stall, so results simply leave as done pulses. Reset
// clears all pipeline valid flags and sets the ranges to 0..1.0.
module linear_range_scaler
    import lrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic signed [WORD_W-1:0] sample_in,
    input  logic                     wr_en,
    input  logic [INDEX_W-1:0]       wr_index,
    input  logic [WORD_W-1:0]        wr_data,
    output logic                     done,
    output logic signed [WORD_W-1:0] sample_out,
    output logic                     divide_by_zero,
    output logic                     saturated
);

    logic  q_full, push, pop;
    item_t push_item, pop_item;

    lrs_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operation(operation),
        .sample_in(sample_in),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .push     (push),
        .push_item(push_item)
    );

    lrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (pop),
        .pop_item (pop_item)
    );

    lrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_item      (pop_item),
        .done          (done),
        .sample_out    (sample_out),
        .divide_by_zero(divide_by_zero),
        .saturated     (saturated)
    );

endmodule

### design/lrs_front.sv
// Front end: configuration registers, transaction accept and span setup.
module lrs_front
    import lrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic signed [WORD_W-1:0] sample_in,
    input  logic                     wr_en,
    input  logic [INDEX_W-1:0]       wr_index,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     q_full,
    output logic                     push,
    output item_t                    push_item
);

    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

    logic [WORD_W-1:0] raw_low_reg, raw_high_reg, eu_low_reg, eu_high_reg;
    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic [WORD_W-1:0] in_lo, in_hi, out_lo, out_hi;
    logic              accept;

    assign busy = valid_reg && q_full;
    assign accept = start && !busy;
    assign push = valid_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        if (operation == OP_RAW_TO_EU)
        begin
            in_lo = raw_low_reg;
            in_hi = raw_high_reg;
            out_lo = eu_low_reg;
            out_hi = eu_high_reg;
        end
        else
        begin
            in_lo = eu_low_reg;
            in_hi = eu_high_reg;
            out_lo = raw_low_reg;
            out_hi = raw_high_reg;
        end
        item_next.diff = $signed({sample_in[WORD_W-1], sample_in})
                       - $signed({in_lo[WORD_W-1], in_lo});
        item_next.span_out = $signed({out_hi[WORD_W-1], out_hi})
                           - $signed({out_lo[WORD_W-1], out_lo});
        item_next.span_in = $signed({in_hi[WORD_W-1], in_hi})
                          - $signed({in_lo[WORD_W-1], in_lo});
        item_next.out_lo = out_lo;
        item_next.x = sample_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_low_reg <= '0;
            raw_high_reg <= ONE;
            eu_low_reg <= '0;
            eu_high_reg <= ONE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RAW_LOW:  raw_low_reg <= wr_data;
                REG_RAW_HIGH: raw_high_reg <= wr_data;
                REG_EU_LOW:   eu_low_reg <= wr_data;
                REG_EU_HIGH:  eu_high_reg <= wr_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

### design/lrs_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
module lrs_queue
    import lrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  pop,
    output item_t pop_item
);

    item_t      mem [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    // The back end never stalls, so any stored entry leaves at once.
    assign pop = (count_reg != 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### design/lrs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module lrs_div
    import lrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  div_stage_t div_in,
    output div_stage_t div_out
);

    div_stage_t stage_reg [0:PROD_W];

    assign div_out = stage_reg[PROD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg[0] <= '0;
        else
            stage_reg[0] <= div_in;
    end

    for (genvar i = 0; i < PROD_W; i++)
    begin : g_stage
        logic [SPAN_W-1:0] trial;
        logic              ge;

        // The remainder stays below the divisor, so its top bit is always zero.
        assign trial = {stage_reg[i].rem[SPAN_W-2:0], stage_reg[i].nq[PROD_W-1]};
        assign ge = (trial >= stage_reg[i].den);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_reg[i+1] <= '0;
            else
            begin
                stage_reg[i+1].valid <= stage_reg[i].valid;
                stage_reg[i+1].rem <= ge ? trial - stage_reg[i].den : trial;
                stage_reg[i+1].nq <= {stage_reg[i].nq[PROD_W-2:0], ge};
                stage_reg[i+1].den <= stage_reg[i].den;
                stage_reg[i+1].side <= stage_reg[i].side;
            end
        end
    end

endmodule

### design/lrs_back.sv
// Back end: magnitudes, split multiply, division, rounding and saturation.
module lrs_back
    import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop,
    input  item_t             pop_item,
    output logic              done,
    output logic [WORD_W-1:0] sample_out,
    output logic              divide_by_zero,
    output logic              saturated
);

    localparam int LO_PROD_W = SPAN_W + SPLIT_W;
    localparam int HI_PROD_W = SPAN_W + SPAN_W - SPLIT_W;
    localparam int SUM_W = SPAN_W + 4;
    localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(1) << (WORD_W + 2);

    // Magnitude stage.
    logic              a_valid_reg;
    logic [SPAN_W-1:0] a_ma_reg, a_mb_reg, a_den_reg;
    side_t             a_side_reg;
    side_t             a_side_next;

    // Partial product stage.
    logic                 b_valid_reg;
    logic [LO_PROD_W-1:0] b_lo_reg;
    logic [HI_PROD_W-1:0] b_hi_reg;
    logic [SPAN_W-1:0]    b_den_reg;
    side_t                b_side_reg;

    div_stage_t div_in, div_out;

    // Rounding stage.
    logic                    r_valid_reg;
    logic                    r_big_reg;
    logic signed [SUM_W-1:0] r_sum_reg;
    side_t                   r_side_reg;
    logic [PROD_W-1:0]       q_round;
    logic signed [SUM_W-1:0] q_signed;

    logic                    done_reg, dz_reg, sat_reg;
    logic [WORD_W-1:0]       out_reg;
    logic [WORD_W-1:0]       out_next;
    logic                    sat_next;

    function automatic logic [SPAN_W-1:0] mag(input logic signed [SPAN_W-1:0] v);
        mag = v[SPAN_W-1] ? SPAN_W'(-v) : SPAN_W'(v);
    endfunction

    always_comb
    begin
        a_side_next.neg = (pop_item.diff[SPAN_W-1] ^ pop_item.span_out[SPAN_W-1])
                        ^ pop_item.span_in[SPAN_W-1];
        a_side_next.dz = (pop_item.span_in == '0);
        a_side_next.out_lo = pop_item.out_lo;
        a_side_next.x = pop_item.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg;
            r_valid_reg <= div_out.valid;
            done_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ma_reg <= mag(pop_item.diff);
        a_mb_reg <= mag(pop_item.span_out);
        a_den_reg <= mag(pop_item.span_in);
        a_side_reg <= a_side_next;

        b_lo_reg <= a_ma_reg * a_mb_reg[SPLIT_W-1:0];
        b_hi_reg <= a_ma_reg * a_mb_reg[SPAN_W-1:SPLIT_W];
        b_den_reg <= a_den_reg;
        b_side_reg <= a_side_reg;
    end

    always_comb
    begin
        div_in.valid = b_valid_reg;
        div_in.nq = PROD_W'(b_lo_reg) + (PROD_W'(b_hi_reg) << SPLIT_W);
        div_in.rem = '0;
        // A zero divisor is replaced so that the divider stays well defined.
        div_in.den = (b_den_reg == '0) ? SPAN_W'(1) : b_den_reg;
        div_in.side = b_side_reg;
    end

    lrs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .div_in (div_in),
        .div_out(div_out)
    );

    always_comb
    begin
        q_round = div_out.nq + PROD_W'({div_out.rem, 1'b0} >= {1'b0, div_out.den});
        q_signed = $signed({1'b0, q_round[SUM_W-2:0]});
        if (div_out.side.neg)
            q_signed = -q_signed;
    end

    always_ff @(posedge clk)
    begin
        r_big_reg <= (q_round > Q_LIMIT);
        r_sum_reg <= q_signed
                   + $signed({{(SUM_W-WORD_W){div_out.side.out_lo[WORD_W-1]}},
                              div_out.side.out_lo});
        r_side_reg <= div_out.side;
    end

    always_comb
    begin
        sat_next = 1'b0;
        if (r_side_reg.dz)
            out_next = r_side_reg.x;
        else if (r_big_reg)
        begin
            sat_next = 1'b1;
            out_next = r_side_reg.neg ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (r_sum_reg > $signed(SUM_W'({1'b0, {(WORD_W-1){1'b1}}})))
        begin
            sat_next = 1'b1;
            out_next = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (r_sum_reg < -$signed(SUM_W'({1'b1, {(WORD_W-1){1'b0}}})))
        begin
            sat_next = 1'b1;
            out_next = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
            out_next = r_sum_reg[WORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        dz_reg <= r_side_reg.dz;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign sample_out = out_reg;
    assign divide_by_zero = dz_reg;
    assign saturated = sat_reg;

endmodule

### tb/linear_range_scaler_test.sv
// Self-checking testbench for the scaler: directed and random commands checked against a predictor.
module linear_range_scaler_test;
    import lrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                     op;
        logic signed [WORD_W-1:0] sample;
    } command_t;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic                     dz;
        logic                     sat;
    } scaled_t;

    localparam int LATENCY = 72;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     operation = 1'b0;
    logic signed [WORD_W-1:0] sample_in = '0;
    logic                     wr_en = 1'b0;
    logic [INDEX_W-1:0]       wr_index = '0;
    logic [WORD_W-1:0]        wr_data = '0;
    logic                     done;
    logic signed [WORD_W-1:0] sample_out;
    logic                     divide_by_zero;
    logic                     saturated;

    linear_range_scaler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .sample_in(sample_in),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .sample_out(sample_out),
        .divide_by_zero(divide_by_zero), .saturated(saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Range points as seen by the predictor.
    logic signed [WORD_W-1:0] raw_lo_m, raw_hi_m, eu_lo_m, eu_hi_m;

    command_t pending_cmds[$];
    scaled_t  expected_results[$];
    int       gap_left = 0;
    int       accepted = 0, checked = 0, mismatches = 0, dz_seen = 0, sat_seen = 0;
    int       idle_cycles = 0;
    logic     write_req = 1'b0;
    logic [INDEX_W-1:0] write_idx;
    logic [WORD_W-1:0]  write_val;

    function automatic scaled_t scale_sample(logic op, logic signed [WORD_W-1:0] x);
        longint in_lo, in_hi, out_lo, out_hi, diff, span_in, span_out, s;
        longint unsigned num, den, q, r;
        logic neg;
        scaled_t res;
        if (op == OP_RAW_TO_EU)
        begin
            in_lo = raw_lo_m; in_hi = raw_hi_m; out_lo = eu_lo_m; out_hi = eu_hi_m;
        end
        else
        begin
            in_lo = eu_lo_m; in_hi = eu_hi_m; out_lo = raw_lo_m; out_hi = raw_hi_m;
        end
        res.dz = 1'b0;
        res.sat = 1'b0;
        diff = longint'(x) - in_lo;
        span_in = in_hi - in_lo;
        span_out = out_hi - out_lo;
        if (span_in == 0)
        begin
            res.value = x;
            res.dz = 1'b1;
            return res;
        end
        num = longint'(diff < 0 ? -diff : diff) * longint'(span_out < 0 ? -span_out : span_out);
        den = span_in < 0 ? -span_in : span_in;
        neg = ((diff < 0) != (span_out < 0)) != (span_in < 0);
        q = num / den;
        r = num % den;
        if (2 * r >= den)
            q++;
        if (q > (64'd1 << 34))
        begin
            res.sat = 1'b1;
            res.value = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            return res;
        end
        s = neg ? -longint'(q) : longint'(q);
        s += out_lo;
        if (s > 64'sd2147483647)
        begin
            s = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (s < -64'sd2147483648)
        begin
            s = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.value = s[WORD_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $urandom_range(0, 32'h0003_FFFF) - 32'sh0002_0000;
            3: return $urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000;
            default: return $urandom();
        endcase
    endfunction

    // Driver: one transaction per cycle at most, random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(scale_sample(operation, sample_in));
                accepted++;
            end
            if (start && busy)
                ;
            else if (gap_left > 0 || pending_cmds.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                command_t c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                operation <= c.op;
                sample_in <= c.sample;
                gap_left <= pick_gap();
            end
        end
    end

    // Configuration writes requested by the stimulus process.
    always @(posedge clk)
    begin
        wr_en <= write_req;
        wr_index <= write_idx;
        wr_data <= write_val;
        if (write_req)
        begin
            case (write_idx)
                REG_RAW_LOW: raw_lo_m = write_val;
                REG_RAW_HIGH: raw_hi_m = write_val;
                REG_EU_LOW: eu_lo_m = write_val;
                default: eu_hi_m = write_val;
            endcase
        end
    end

    // Monitor: every done pulse is matched with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            scaled_t e;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: sample_out=%0d", sample_out);
            end
            else
            begin
                e = expected_results.pop_front();
                checked++;
                if (e.dz) dz_seen++;
                if (e.sat) sat_seen++;
                if (sample_out !== e.value || divide_by_zero !== e.dz || saturated !== e.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d dz=%0b sat=%0b, got %0d dz=%0b sat=%0b",
                                 e.value, e.dz, e.sat, sample_out, divide_by_zero, saturated);
                end
            end
        end
    end

    // Watchdog on cycles with work pending but no accepted transaction or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (pending_cmds.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge clk);
        write_req <= 1'b1;
        write_idx <= idx;
        write_val <= val;
        @(posedge clk);
        write_req <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_cmd(logic op, logic signed [WORD_W-1:0] x);
        command_t c;
        c.op = op;
        c.sample = x;
        pending_cmds.push_back(c);
    endtask

    task automatic load_ranges(logic [WORD_W-1:0] rl, logic [WORD_W-1:0] rh,
                               logic [WORD_W-1:0] el, logic [WORD_W-1:0] eh);
        write_reg(REG_RAW_LOW, rl);
        write_reg(REG_RAW_HIGH, rh);
        write_reg(REG_EU_LOW, el);
        write_reg(REG_EU_HIGH, eh);
    endtask

    initial
    begin
        raw_lo_m = 0;
        raw_hi_m = 32'sd65536;
        eu_lo_m = 0;
        eu_hi_m = 32'sd65536;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset ranges, raw-to-units extremes and small samples of both operations.
        queue_cmd(1'b0, 32'sh8000_0000);
        queue_cmd(1'b0, 32'sh7FFF_FFFF);
        queue_cmd(1'b1, 32'sd0);
        queue_cmd(1'b1, 32'sd32768);
        queue_cmd(1'b0, -32'sd1);
        drain();
        // Widest spans, inverted, with samples at both ends.
        load_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_cmd(1'b0, 32'sh8000_0000);
        queue_cmd(1'b0, 32'sh7FFF_FFFF);
        queue_cmd(1'b1, 32'sh8000_0000);
        queue_cmd(1'b1, 32'sh7FFF_FFFF);
        queue_cmd(1'b0, 32'sd0);
        drain();
        // Tiny raw span, huge gain: saturation.
        load_ranges(32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_cmd(1'b0, 32'sd5);
        queue_cmd(1'b0, -32'sd5);
        queue_cmd(1'b1, 32'sd12345);
        queue_cmd(1'b0, 32'sd1);
        drain();
        // Zero raw span, then zero units span.
        load_ranges(32'd7, 32'd7, 32'd0, 32'd3);
        queue_cmd(1'b0, 32'sh7FFF_FFFF);
        queue_cmd(1'b0, 32'sh8000_0000);
        queue_cmd(1'b1, 32'sd2);
        drain();
        load_ranges(32'd0, 32'd3, 32'd9, 32'd9);
        queue_cmd(1'b1, 32'sd1234);
        queue_cmd(1'b0, 32'sd1);
        queue_cmd(1'b0, 32'sd2);
        drain();

        // Random phases with fresh ranges each time; some spans are zero.
        for (int phase = 0; phase < 32; phase++)
        begin
            logic [WORD_W-1:0] rl, rh, el, eh;
            rl = pick_value();
            rh = ($urandom_range(0, 9) == 0) ? rl : pick_value();
            el = pick_value();
            eh = ($urandom_range(0, 9) == 0) ? el : pick_value();
            load_ranges(rl, rh, el, eh);
            for (int i = 0; i < 50; i++)
                queue_cmd(1'($urandom_range(0, 1)), pick_value());
            drain();
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d of %0d transactions over 37 range settings;", checked, accepted);
        $display("%0d divide-by-zero and %0d saturated results seen.", dz_seen, sat_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
